// ----- design/bfd_pkg.sv -----
// shared types, constants and helpers of the fractional baud divisor
package bfd_pkg;

    localparam int unsigned BAUD_W     = 24;
    localparam int unsigned WORD_W     = 22;
    localparam int unsigned CLASS_W    = 2;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned DIVIDEND_W = 27;
    localparam int unsigned DIV_STAGES = DIVIDEND_W;

    // config register index
    localparam logic CFG_CHIP_CLASS   = 1'b0;
    localparam logic CFG_REMAP_QUIRK  = 1'b1;

    // chip class codes
    localparam logic [CLASS_W-1:0] CLASS_TABLE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_AM    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_BM    = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HS    = 2'd3;
    localparam logic [CLASS_W-1:0] CLASS_RESET = CLASS_BM;

    // word formatting mode, chosen at decode
    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_AM    = 2'd1;
    localparam logic [1:0] MODE_BM    = 2'd2;
    localparam logic [1:0] MODE_HS    = 2'd3;

    // dividends: 48 MHz / 2 and 120 MHz * 8 / 10
    localparam logic [DIVIDEND_W-1:0] LOW_DIVIDEND = 27'd24000000;
    localparam logic [DIVIDEND_W-1:0] HS_DIVIDEND  = 27'd96000000;

    localparam logic [BAUD_W-1:0] DEFAULT_BAUD    = 24'd9600;
    localparam logic [BAUD_W-1:0] LOW_MAX_BAUD    = 24'd3000000;
    localparam logic [BAUD_W-1:0] HIGH_MAX_BAUD   = 24'd12000000;
    localparam logic [BAUD_W-1:0] HIGH_MIN_BAUD   = 24'd1200;
    localparam logic [BAUD_W-1:0] QUIRK_FROM_BAUD = 24'd19200;
    localparam logic [BAUD_W-1:0] QUIRK_TO_BAUD   = 24'd1200000;

    localparam logic [WORD_W-1:0] HIGH_SPEED_BIT  = 22'h020000;
    localparam logic [WORD_W-1:0] TOP_PAIR_WORD   = 22'h004001;
    localparam logic [15:0]       AM_FRAC_EIGHTH  = 16'hc000;
    localparam logic [15:0]       AM_FRAC_HALF    = 16'h4000;
    localparam logic [15:0]       AM_FRAC_QUARTER = 16'h8000;

    localparam int unsigned TABLE_LEN = 10;
    localparam logic [CODE_W-1:0] TABLE_DEFAULT_CODE = 4'd5;
    localparam logic [BAUD_W-1:0] TABLE_RATES [TABLE_LEN] = '{
        24'd300, 24'd600, 24'd1200, 24'd2400, 24'd4800,
        24'd9600, 24'd19200, 24'd38400, 24'd57600, 24'd115200
    };

    typedef struct packed {
        logic [1:0]        mode;
        logic [CODE_W-1:0] code;
        logic              ok;
        logic [BAUD_W-1:0] baud;
    } t_side;

    typedef struct packed {
        t_side                 side;
        logic [BAUD_W-1:0]     rem;
        logic [DIVIDEND_W-1:0] quo;
    } t_lane;

    // fraction code for the low three quotient bits
    function automatic logic [2:0] frac_code(input logic [2:0] f);
        logic [2:0] c;
        case (f)
            3'd0:    c = 3'd0;
            3'd1:    c = 3'd3;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd4;
            3'd4:    c = 3'd1;
            3'd5:    c = 3'd5;
            3'd6:    c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

endpackage

// ----- design/bfd_div_cell.sv -----
// one restoring divider cell: decides one quotient bit per word
module bfd_div_cell #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bfd_pkg::t_lane i_lane,
    output logic           o_valid,
    input  logic           i_ready,
    output bfd_pkg::t_lane o_lane
);

    logic                        r_valid;
    bfd_pkg::t_lane              r_lane;
    bfd_pkg::t_lane              n_lane;
    logic                        dividend_bit;
    logic [bfd_pkg::BAUD_W:0]    trial;
    logic [bfd_pkg::BAUD_W:0]    diff;
    logic                        take;

    always_comb begin
        dividend_bit = (i_lane.side.mode == bfd_pkg::MODE_HS) ?
                       bfd_pkg::HS_DIVIDEND[BIT_POS] : bfd_pkg::LOW_DIVIDEND[BIT_POS];
        trial = {i_lane.rem, dividend_bit};
        diff  = trial - {1'b0, i_lane.side.baud};
        take  = (trial >= {1'b0, i_lane.side.baud});
        n_lane      = i_lane;
        n_lane.rem  = take ? diff[bfd_pkg::BAUD_W-1:0] : trial[bfd_pkg::BAUD_W-1:0];
        n_lane.quo  = {i_lane.quo[bfd_pkg::DIVIDEND_W-2:0], take};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_lane  = r_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_lane <= n_lane;
        end
    end

endmodule

// ----- design/bfd_word_fmt.sv -----
// turns the quotient into the generator word for the selected mode
module bfd_word_fmt (
    input  bfd_pkg::t_side                  i_side,
    input  logic [bfd_pkg::DIVIDEND_W-1:0]  i_quo,
    output logic [bfd_pkg::WORD_W-1:0]      o_word
);

    logic [18:0]                 am_d;
    logic [15:0]                 am_w;
    logic [bfd_pkg::WORD_W-1:0]  bm_raw;
    logic [bfd_pkg::WORD_W-1:0]  bm_w;

    always_comb begin
        // am: round 7/8 up, keep 16 bits of integer, then or in the flags
        am_d = i_quo[18:0];
        if (am_d[2:0] == 3'b111) begin
            am_d = am_d + 19'd1;
        end
        am_w = am_d[18:3];
        if (am_d[2:0] == 3'd1) begin
            am_w = am_w | bfd_pkg::AM_FRAC_EIGHTH;
        end else if (am_d[2:0] >= 3'd4) begin
            am_w = am_w | bfd_pkg::AM_FRAC_HALF;
        end else if (am_d[2:0] != 3'd0) begin
            am_w = am_w | bfd_pkg::AM_FRAC_QUARTER;
        end else if (am_w == 16'd1) begin
            am_w = 16'd0;
        end

        // bm/hs: integer part with fraction code at bit 14, top rates fixed up
        bm_raw = i_quo[24:3]
               | {5'd0, bfd_pkg::frac_code(i_quo[2:0]), 14'd0};
        if (bm_raw == {{(bfd_pkg::WORD_W-1){1'b0}}, 1'b1}) begin
            bm_w = '0;
        end else if (bm_raw == bfd_pkg::TOP_PAIR_WORD) begin
            bm_w = {{(bfd_pkg::WORD_W-1){1'b0}}, 1'b1};
        end else begin
            bm_w = bm_raw;
        end

        case (i_side.mode)
            bfd_pkg::MODE_TABLE: o_word = {18'd0, i_side.code};
            bfd_pkg::MODE_AM:    o_word = {6'd0, am_w};
            bfd_pkg::MODE_BM:    o_word = bm_w;
            bfd_pkg::MODE_HS:    o_word = bm_w | bfd_pkg::HIGH_SPEED_BIT;
            default:             o_word = bm_w;
        endcase
    end

endmodule

// ----- design/baud_fractional_divisor_core.sv -----
// top level of the fractional baud divisor: decode, divider chain, output word
//
// Takes one requested baud rate per word and returns the generator word, an
// ok flag and the baud rate actually used. A request of zero means 9600. The
// chip class register picks the fixed table, the 48 MHz AM formula, the
// 48 MHz BM formula or the 120 MHz high-speed formula (BM below 1200); a rate
// that is too high or not in the table falls back to 9600 with ok cleared. The
// pipeline is one decode stage, a chain of 27 divider cells and the output
// register. A new word is accepted every cycle unless back-pressure from the
// output stalls the chain; there is one restoring cell per quotient bit, all
// cells working on different words at once. Every stage has its own valid
// bit, so bubbles collapse and the chain keeps filling while a result waits
// at the output. Configuration writes take effect on the next accepted request.
module baud_fractional_divisor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bfd_pkg::BAUD_W-1:0]    i_requested_baud,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bfd_pkg::WORD_W-1:0]    o_divisor_word,
    output logic                          o_rate_ok,
    output logic [bfd_pkg::BAUD_W-1:0]    o_effective_baud,
    // config write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bfd_pkg::CLASS_W-1:0]   i_cfg_data
);

    // config registers
    logic [bfd_pkg::CLASS_W-1:0] r_chip_class;
    logic                        r_remap_quirk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_class  <= bfd_pkg::CLASS_RESET;
            r_remap_quirk <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfd_pkg::CFG_CHIP_CLASS:  r_chip_class  <= i_cfg_data;
                bfd_pkg::CFG_REMAP_QUIRK: r_remap_quirk <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // request decode: default rate, range checks, quirk and table lookup
    bfd_pkg::t_side              n_side;
    logic [bfd_pkg::BAUD_W-1:0]  req_baud;
    logic                        tbl_found;
    logic [bfd_pkg::CODE_W-1:0]  tbl_code;

    always_comb begin
        req_baud  = (i_requested_baud == '0) ? bfd_pkg::DEFAULT_BAUD : i_requested_baud;
        tbl_found = 1'b0;
        tbl_code  = bfd_pkg::TABLE_DEFAULT_CODE;
        for (int k = 0; k < bfd_pkg::TABLE_LEN; k++) begin
            if (bfd_pkg::TABLE_RATES[k] == req_baud) begin
                tbl_found = 1'b1;
                tbl_code  = k[bfd_pkg::CODE_W-1:0];
            end
        end

        n_side.mode = bfd_pkg::MODE_BM;
        n_side.code = tbl_code;
        n_side.ok   = 1'b1;
        n_side.baud = req_baud;

        case (r_chip_class)
            bfd_pkg::CLASS_TABLE: begin
                n_side.mode = bfd_pkg::MODE_TABLE;
                if (!tbl_found) begin
                    n_side.ok   = 1'b0;
                    n_side.baud = bfd_pkg::DEFAULT_BAUD;
                end
            end
            bfd_pkg::CLASS_AM: begin
                n_side.mode = bfd_pkg::MODE_AM;
                if (req_baud > bfd_pkg::LOW_MAX_BAUD) begin
                    n_side.ok   = 1'b0;
                    n_side.baud = bfd_pkg::DEFAULT_BAUD;
                end
            end
            bfd_pkg::CLASS_BM: begin
                if (req_baud > bfd_pkg::LOW_MAX_BAUD) begin
                    n_side.ok   = 1'b0;
                    n_side.baud = bfd_pkg::DEFAULT_BAUD;
                end else if (r_remap_quirk && req_baud == bfd_pkg::QUIRK_FROM_BAUD) begin
                    n_side.baud = bfd_pkg::QUIRK_TO_BAUD;
                end
            end
            default: begin
                // high-speed class; below its floor it uses the bm formula
                if (req_baud > bfd_pkg::HIGH_MAX_BAUD) begin
                    n_side.ok   = 1'b0;
                    n_side.baud = bfd_pkg::DEFAULT_BAUD;
                end else if (req_baud >= bfd_pkg::HIGH_MIN_BAUD) begin
                    n_side.mode = bfd_pkg::MODE_HS;
                end
            end
        endcase
    end

    // decode stage register
    logic           r_dec_valid;
    bfd_pkg::t_lane r_dec_lane;
    logic           dec_ready;

    logic           cell_valid [bfd_pkg::DIV_STAGES+1];
    logic           cell_ready [bfd_pkg::DIV_STAGES+1];
    bfd_pkg::t_lane cell_lane  [bfd_pkg::DIV_STAGES+1];

    assign dec_ready  = !r_dec_valid || cell_ready[0];
    assign o_in_ready = dec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (dec_ready) begin
            r_dec_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_ready) begin
            r_dec_lane.side <= n_side;
            r_dec_lane.rem  <= '0;
            r_dec_lane.quo  <= '0;
        end
    end

    assign cell_valid[0] = r_dec_valid;
    assign cell_lane[0]  = r_dec_lane;

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < bfd_pkg::DIV_STAGES; g++) begin : g_cell
        bfd_div_cell #(
            .BIT_POS(bfd_pkg::DIV_STAGES - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .o_ready (cell_ready[g]),
            .i_lane  (cell_lane[g]),
            .o_valid (cell_valid[g+1]),
            .i_ready (cell_ready[g+1]),
            .o_lane  (cell_lane[g+1])
        );
    end

    // word formatting and output register
    logic [bfd_pkg::WORD_W-1:0] fmt_word;

    bfd_word_fmt u_fmt (
        .i_side (cell_lane[bfd_pkg::DIV_STAGES].side),
        .i_quo  (cell_lane[bfd_pkg::DIV_STAGES].quo),
        .o_word (fmt_word)
    );

    logic                        r_out_valid;
    logic [bfd_pkg::WORD_W-1:0]  r_word;
    logic                        r_ok;
    logic [bfd_pkg::BAUD_W-1:0]  r_baud;

    assign cell_ready[bfd_pkg::DIV_STAGES] = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cell_ready[bfd_pkg::DIV_STAGES]) begin
            r_out_valid <= cell_valid[bfd_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ready[bfd_pkg::DIV_STAGES]) begin
            r_word <= fmt_word;
            r_ok   <= cell_lane[bfd_pkg::DIV_STAGES].side.ok;
            r_baud <= cell_lane[bfd_pkg::DIV_STAGES].side.baud;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_divisor_word   = r_word;
    assign o_rate_ok        = r_ok;
    assign o_effective_baud = r_baud;

endmodule

// ----- design/bfd_checker.sv -----
// port-level checks of the fractional baud divisor, bound to the top level
module bfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [bfd_pkg::WORD_W-1:0]  o_divisor_word,
    input logic                        o_rate_ok,
    input logic [bfd_pkg::BAUD_W-1:0]  o_effective_baud
);

    // no result comes out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_divisor_word) && $stable(o_rate_ok)
            && $stable(o_effective_baud))
        else $error("stalled result changed");

    // fallback always reports the default rate
    a_fallback_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rate_ok |-> o_effective_baud == bfd_pkg::DEFAULT_BAUD)
        else $error("fallback rate is not the default");

    // fallback words are small
    a_fallback_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rate_ok |-> o_divisor_word[21:16] == 6'd0)
        else $error("fallback word out of range");

    // high-speed bit only on an accepted rate
    a_hs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divisor_word[17] |-> o_rate_ok)
        else $error("high-speed word on a fallback");

endmodule

bind baud_fractional_divisor_core bfd_checker u_bfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_divisor_word   (o_divisor_word),
    .o_rate_ok        (o_rate_ok),
    .o_effective_baud (o_effective_baud)
);
